// ----- hdl/digital_noise_channel_flagger_assert.svh -----
// Assertion macros for the digital noise channel flagger.
// Used by the top-level RTL file; empty when SYNTHESIS is defined.
`ifndef DIGITAL_NOISE_CHANNEL_FLAGGER_ASSERT_SVH
`define DIGITAL_NOISE_CHANNEL_FLAGGER_ASSERT_SVH

`ifndef SYNTHESIS
`define DNCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DNCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DNCF_ASSERT(lbl, prop, msg)
`define DNCF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/dncf_pkg.sv -----
// Types and constants of the digital noise channel flagger.
// No dependencies.
package dncf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 14;
  localparam int RMS_W    = 16;
  localparam int COUNT_W  = 13;
  localparam int SUNSET_W = 12;
  localparam int SUM_W    = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [SAMPLE_W-1:0] BAD_WORD    = 12'hBAD;
  localparam logic [COUNT_W-1:0]  POST_OFFSET = 13'd500;
  localparam logic [SUM_W-1:0]    SUM_MAX     = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = 13'h1FFF;

  localparam logic [RMS_W-1:0]    RMS_CUT_RST        = 16'd1600;
  localparam logic [COUNT_W-1:0]  BAD_WORD_LIMIT_RST = 13'd5;
  localparam logic [SUNSET_W-1:0] DUSK_TICK_RST      = 12'd500;
  localparam logic [SUM_W-1:0]    ACTIVITY_LIMIT_RST = 24'd50000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RMS_CUT        = 2'd0,
    CFG_BAD_WORD_LIMIT = 2'd1,
    CFG_DUSK_TICK      = 2'd2,
    CFG_ACTIVITY_LIMIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RMS_W-1:0]    rms_cut;
    logic [COUNT_W-1:0]  bad_word_limit;
    logic [SUNSET_W-1:0] dusk_tick;
    logic [SUM_W-1:0]    activity_limit;
  } cfg_t;

  // Channel statistics including the sample just taken
  typedef struct packed {
    logic [COUNT_W-1:0] bad_word_count;
    logic               parity_same;
    logic [SUM_W-1:0]   pre_sum;
    logic [SUM_W-1:0]   post_sum;
  } stats_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_out;
    logic              is_bad;
    logic              rms_flag;
    logic              bad_word_flag;
    logic              parity_stuck;
    logic              activity_flag;
  } result_t;

endpackage

// ----- hdl/dncf_if.sv -----
// Stream interfaces of the flagger: sample input and verdict output.
// Depends on dncf_pkg.
interface dncf_in_if;
  import dncf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [CHAN_W-1:0]   channel_id;
  logic [RMS_W-1:0]    channel_rms;
  logic                last_sample;
  modport source (output valid, sample, channel_id, channel_rms, last_sample, input ready);
  modport sink   (input valid, sample, channel_id, channel_rms, last_sample, output ready);
endinterface

interface dncf_out_if;
  import dncf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel_out;
  logic              is_bad;
  logic              rms_flag;
  logic              bad_word_flag;
  logic              parity_stuck;
  logic              activity_flag;
  modport source (output valid, channel_out, is_bad, rms_flag, bad_word_flag, parity_stuck,
                  activity_flag, input ready);
  modport sink   (input valid, channel_out, is_bad, rms_flag, bad_word_flag, parity_stuck,
                  activity_flag, output ready);
endinterface

// ----- hdl/dncf_cfg_regs.sv -----
// Configuration registers of the flagger, written through a plain write port.
// Depends on dncf_pkg.
module dncf_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [dncf_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [dncf_pkg::CFG_W-1:0]      wdata_i,
  output dncf_pkg::cfg_t                  cfg_o
);
  import dncf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_RMS_CUT:        cfg_d.rms_cut        = wdata_i[RMS_W-1:0];
        CFG_BAD_WORD_LIMIT: cfg_d.bad_word_limit = wdata_i[COUNT_W-1:0];
        CFG_DUSK_TICK:      cfg_d.dusk_tick      = wdata_i[SUNSET_W-1:0];
        CFG_ACTIVITY_LIMIT: cfg_d.activity_limit = wdata_i[SUM_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rms_cut        <= RMS_CUT_RST;
      cfg_q.bad_word_limit <= BAD_WORD_LIMIT_RST;
      cfg_q.dusk_tick      <= DUSK_TICK_RST;
      cfg_q.activity_limit <= ACTIVITY_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/dncf_accum.sv -----
// Per-channel accumulator: tick counter, parity tracking, 0xBAD count and
// the two activity sums. Depends on dncf_pkg.
module dncf_accum #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic [dncf_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                           last_i,
  input  logic [dncf_pkg::SUNSET_W-1:0]  dusk_tick_i,
  output dncf_pkg::stats_t               stats_o
);
  import dncf_pkg::*;

  localparam int TICK_W = $clog2(MAX_SAMPLES);
  localparam int CMP_W  = ((TICK_W > COUNT_W) ? TICK_W : COUNT_W) + 1;
  localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'(MAX_SAMPLES - 1);

  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [SAMPLE_W-1:0] prev_q;
  logic                first_par_q, first_par_d;
  stats_t              stats_q, stats_d;

  logic [SAMPLE_W-1:0] diff;
  logic [SUM_W:0]      pre_add, post_add;
  logic [CMP_W-1:0]    t_ext, pre_edge, post_edge;

  always_comb begin
    diff      = (sample_i > prev_q) ? (sample_i - prev_q) : (prev_q - sample_i);
    t_ext     = CMP_W'(tick_q) - CMP_W'(1);
    pre_edge  = CMP_W'(dusk_tick_i);
    post_edge = CMP_W'(dusk_tick_i) + CMP_W'(POST_OFFSET);
    pre_add   = {1'b0, stats_q.pre_sum} + (SUM_W+1)'(diff);
    post_add  = {1'b0, stats_q.post_sum} + (SUM_W+1)'(diff);

    stats_d     = stats_q;
    first_par_d = first_par_q;

    if (sample_i == BAD_WORD && stats_q.bad_word_count != COUNT_MAX) begin
      stats_d.bad_word_count = stats_q.bad_word_count + COUNT_W'(1);
    end

    if (tick_q == '0) begin
      first_par_d = sample_i[0];
    end else begin
      if (sample_i[0] != first_par_q) stats_d.parity_same = 1'b0;
      // difference belongs to the previous sample's tick
      if (t_ext < pre_edge) begin
        stats_d.pre_sum = pre_add[SUM_W] ? SUM_MAX : pre_add[SUM_W-1:0];
      end else if (t_ext > post_edge) begin
        stats_d.post_sum = post_add[SUM_W] ? SUM_MAX : post_add[SUM_W-1:0];
      end
    end

    tick_d = (tick_q != TICK_MAX) ? tick_q + TICK_W'(1) : tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q                 <= '0;
      prev_q                 <= '0;
      first_par_q            <= 1'b0;
      stats_q.bad_word_count <= '0;
      stats_q.parity_same    <= 1'b1;
      stats_q.pre_sum        <= '0;
      stats_q.post_sum       <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        tick_q                 <= '0;
        prev_q                 <= '0;
        first_par_q            <= 1'b0;
        stats_q.bad_word_count <= '0;
        stats_q.parity_same    <= 1'b1;
        stats_q.pre_sum        <= '0;
        stats_q.post_sum       <= '0;
      end else begin
        tick_q      <= tick_d;
        prev_q      <= sample_i;
        first_par_q <= first_par_d;
        stats_q     <= stats_d;
      end
    end
  end

  assign stats_o = stats_d;

endmodule

// ----- hdl/dncf_verdict.sv -----
// Verdict logic and result register: flags from the final statistics.
// Depends on dncf_pkg.
module dncf_verdict (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  dncf_pkg::stats_t             stats_i,
  input  logic [dncf_pkg::CHAN_W-1:0]  channel_id_i,
  input  logic [dncf_pkg::RMS_W-1:0]   channel_rms_i,
  input  dncf_pkg::cfg_t               cfg_i,
  input  logic                         ready_i,
  output logic                         valid_o,
  output dncf_pkg::result_t            result_o
);
  import dncf_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  always_comb begin
    res_d.channel_out   = channel_id_i;
    res_d.rms_flag      = channel_rms_i > cfg_i.rms_cut;
    res_d.bad_word_flag = stats_i.bad_word_count > cfg_i.bad_word_limit;
    res_d.parity_stuck  = stats_i.parity_same;
    res_d.activity_flag = (stats_i.pre_sum > cfg_i.activity_limit) ||
                          (stats_i.post_sum > cfg_i.activity_limit);
    res_d.is_bad        = res_d.rms_flag | res_d.bad_word_flag |
                          res_d.parity_stuck | res_d.activity_flag;
    valid_d = load_i ? 1'b1 : (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ----- hdl/digital_noise_channel_flagger.sv -----
// Top level of the digital noise channel flagger.
// Depends on dncf_pkg, dncf_if, dncf_cfg_regs, dncf_accum, dncf_verdict.
//
// Takes one 12-bit sample per clock and, on the sample marked last, delivers
// one verdict for the channel (flags for RMS, 0xBAD count, stuck parity and
// activity, plus their OR). Each sample passes an input register and then an
// update of the per-channel statistics, so the sustained rate is one sample
// per cycle; the verdict is loaded into the result register as the last
// sample leaves the input register. Only a last sample waits, and only while
// the previous verdict is still unread. Configuration takes effect for samples
// updated after the write and must be changed only while the block is idle.
module digital_noise_channel_flagger #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dncf_in_if.sink                        in_ch,
  dncf_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [dncf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dncf_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import dncf_pkg::*;
  `include "digital_noise_channel_flagger_assert.svh"

  cfg_t    cfg;
  stats_t  stats;
  result_t result;
  logic    out_valid;

  logic                s1_valid_q, s1_valid_d;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [CHAN_W-1:0]   s1_chan_q;
  logic [RMS_W-1:0]    s1_rms_q;
  logic                s1_last_q;
  logic                advance, in_take, verdict_load;

  // a non-last sample never needs the result register
  assign advance  = s1_valid_q && (!s1_last_q || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || advance;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign s1_valid_d = in_take ? 1'b1 : (s1_valid_q && !advance);
  assign verdict_load = advance && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q <= in_ch.sample;
      s1_chan_q   <= in_ch.channel_id;
      s1_rms_q    <= in_ch.channel_rms;
      s1_last_q   <= in_ch.last_sample;
    end
  end

  dncf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  dncf_accum #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .sample_i      (s1_sample_q),
    .last_i        (s1_last_q),
    .dusk_tick_i   (cfg.dusk_tick),
    .stats_o       (stats)
  );

  dncf_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (verdict_load),
    .stats_i       (stats),
    .channel_id_i  (s1_chan_q),
    .channel_rms_i (s1_rms_q),
    .cfg_i         (cfg),
    .ready_i       (out_ch.ready),
    .valid_o       (out_valid),
    .result_o      (result)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.channel_out   = result.channel_out;
  assign out_ch.is_bad        = result.is_bad;
  assign out_ch.rms_flag      = result.rms_flag;
  assign out_ch.bad_word_flag = result.bad_word_flag;
  assign out_ch.parity_stuck  = result.parity_stuck;
  assign out_ch.activity_flag = result.activity_flag;

  `DNCF_ASSERT(a_no_overwrite, !(verdict_load && out_valid && !out_ch.ready), "verdict lost")
  `DNCF_ASSERT_NEXT(a_verdict_loaded, verdict_load, out_valid, "last sample gave no verdict")
  `DNCF_ASSERT_NEXT(a_stage_kept, s1_valid_q && !advance, s1_valid_q, "input stage item lost")

endmodule

// ----- bench/digital_noise_channel_flagger_test.sv -----
// Self-checking bench for digital_noise_channel_flagger: sample streams in, verdicts out.
// Depends on dncf_pkg, dncf_if and the flagger RTL; an inline predictor holds the
// expected verdicts.
module digital_noise_channel_flagger_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dncf_pkg::*;

  // small tick ceiling so an overlong channel stays short
  localparam int CHAN_MAX_TICKS  = 506;
  localparam int RANDOM_ITEMS    = 300;
  localparam int RANDOM_CHANNELS = 16;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct packed {
    logic [COUNT_W-1:0]  ticks;
    logic [SAMPLE_W-1:0] prev;
    logic                first_par;
    logic                par_same;
    logic [COUNT_W-1:0]  bad_count;
    logic [SUM_W-1:0]    pre;
    logic [SUM_W-1:0]    post;
  } chan_stats_t;

  localparam chan_stats_t CHAN_CLEAR = '{ticks: '0, prev: '0, first_par: 1'b0,
                                         par_same: 1'b1, bad_count: '0, pre: '0,
                                         post: '0};

  typedef enum int {
    WAVE_RANDOM,
    WAVE_QUIET,
    WAVE_FIXED_PARITY,
    WAVE_SPRINKLED_BAD,
    WAVE_ALL_BAD,
    WAVE_SQUARE
  } wave_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  dncf_in_if  in_ch();
  dncf_out_if out_ch();

  cfg_t        flag_cfg;
  chan_stats_t chan;
  result_t     verdict_q[$];
  int          burst_left = 0;
  int          mismatch_count = 0;

  digital_noise_channel_flagger #(
    .MAX_SAMPLES(CHAN_MAX_TICKS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [SAMPLE_W-1:0] d);
    logic [SUM_W:0] total;
    total = acc + d;
    return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  // Advance the channel statistics by one accepted sample; queue a verdict on the last one
  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] id,
                                   input logic [RMS_W-1:0] rms, input logic last);
    logic [COUNT_W-1:0]  t;
    logic [SAMPLE_W-1:0] d;
    logic [COUNT_W:0]    post_start;
    result_t             v;
    if (s == BAD_WORD && chan.bad_count < COUNT_MAX) chan.bad_count++;
    if (chan.ticks == 0) begin
      chan.first_par = s[0];
    end else begin
      t = chan.ticks - 1'b1;
      d = (s > chan.prev) ? s - chan.prev : chan.prev - s;
      if (s[0] != chan.first_par) chan.par_same = 1'b0;
      post_start = {2'b00, flag_cfg.dusk_tick} + (COUNT_W+1)'(POST_OFFSET);
      if (t < {1'b0, flag_cfg.dusk_tick}) begin
        chan.pre = sat_sum(chan.pre, d);
      end else if ({1'b0, t} > post_start) begin
        chan.post = sat_sum(chan.post, d);
      end
    end
    chan.prev = s;
    if (chan.ticks < CHAN_MAX_TICKS - 1) chan.ticks++;
    if (last) begin
      v.channel_out   = id;
      v.rms_flag      = rms > flag_cfg.rms_cut;
      v.bad_word_flag = chan.bad_count > flag_cfg.bad_word_limit;
      v.parity_stuck  = chan.par_same;
      v.activity_flag = (chan.pre > flag_cfg.activity_limit) ||
                        (chan.post > flag_cfg.activity_limit);
      v.is_bad = v.rms_flag | v.bad_word_flag | v.parity_stuck | v.activity_flag;
      verdict_q = {verdict_q, v};
      chan = CHAN_CLEAR;
    end
  endtask

  // One transaction on the sample channel, with bursty gaps in front
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] id,
                             input logic [RMS_W-1:0] rms, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk_i);
        in_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid       = 1'b1;
    in_ch.sample      = s;
    in_ch.channel_id  = id;
    in_ch.channel_rms = rms;
    in_ch.last_sample = last;
    do @(posedge clk_i); while (!in_ch.ready);
    accumulate_sample(s, id, rms, last);
  endtask

  task automatic send_channel(input int len, input wave_e wave, input logic [CHAN_W-1:0] id);
    int                  i;
    int                  level;
    int                  ped;
    logic                par;
    logic [SAMPLE_W-1:0] s;
    logic [RMS_W-1:0]    rms;
    ped = $urandom_range(0, 4095);
    par = 1'($urandom_range(0, 1));
    for (i = 0; i < len; i++) begin
      case (wave)
        WAVE_QUIET: begin
          level = ped + int'($urandom_range(0, 6)) - 3;
          if (level < 0) level = 0;
          if (level > 4095) level = 4095;
          s = SAMPLE_W'(level);
        end
        WAVE_FIXED_PARITY: begin
          s    = SAMPLE_W'($urandom);
          s[0] = par;
        end
        WAVE_SPRINKLED_BAD: s = ($urandom_range(0, 9) < 3) ? BAD_WORD : SAMPLE_W'($urandom);
        WAVE_ALL_BAD:       s = BAD_WORD;
        WAVE_SQUARE:        s = i[0] ? 12'hFFF : 12'h000;
        default:            s = SAMPLE_W'($urandom);
      endcase
      // half the time sit within two of the RMS cut
      if ($urandom_range(0, 1) == 1) begin
        rms = RMS_W'($urandom);
      end else begin
        level = int'(flag_cfg.rms_cut) + int'($urandom_range(0, 4)) - 2;
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        rms = RMS_W'(level);
      end
      send_sample(s, id, rms, i == len - 1);
    end
  endtask

  // Lower valid, let every queued verdict arrive, then give the pipeline time to empty
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid       = 1'b0;
    in_ch.last_sample = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_RMS_CUT:        flag_cfg.rms_cut        = value[RMS_W-1:0];
      CFG_BAD_WORD_LIMIT: flag_cfg.bad_word_limit = value[COUNT_W-1:0];
      CFG_DUSK_TICK:      flag_cfg.dusk_tick      = value[SUNSET_W-1:0];
      CFG_ACTIVITY_LIMIT: flag_cfg.activity_limit = value[SUM_W-1:0];
      default: ;
    endcase
  endtask

  // Reset cuts: short channels, RMS and 0xBAD count on either side of the cut
  task automatic test_default_cuts();
    int i;
    send_sample(12'hFFF, 14'h3FFF, 16'hFFFF, 1'b1);
    send_sample(12'h000, 14'h0000, 16'h0000, 1'b1);
    send_sample(12'h000, 14'h0123, 16'h0000, 1'b0);
    send_sample(12'h001, 14'h0123, RMS_CUT_RST, 1'b1);
    send_sample(12'h000, 14'h0124, 16'h0000, 1'b0);
    send_sample(12'h001, 14'h0124, RMS_CUT_RST + 1'b1, 1'b1);
    for (i = 0; i < 5; i++) send_sample(BAD_WORD, 14'h0200, 16'h0000, 1'b0);
    send_sample(12'h000, 14'h0200, 16'h0000, 1'b1);
    send_sample(12'h000, 14'h0201, 16'h0000, 1'b0);
    for (i = 0; i < 6; i++) send_sample(BAD_WORD, 14'h0201, 16'h0000, i == 5);
    send_sample(12'hFFF, 14'h2000, 16'h0000, 1'b0);
    send_sample(12'h000, 14'h2000, 16'h0000, 1'b1);
  endtask

  // Sunset at 3: steps at ticks 3 and 503 fall in the dead band, 2 does not.
  // The third channel outruns the tick ceiling, so its last step uses the held tick.
  task automatic test_activity_windows();
    int i;
    int j;
    int chan_len[3]   = '{505, 6, 508};
    int jump_ticks[3] = '{4095, 2, 506};
    wait_idle();
    write_reg(CFG_RMS_CUT, 24'h00FFFF);
    write_reg(CFG_BAD_WORD_LIMIT, 24'd0);
    write_reg(CFG_DUSK_TICK, 24'd3);
    write_reg(CFG_ACTIVITY_LIMIT, 24'd0);
    for (j = 0; j < 3; j++) begin
      for (i = 0; i < chan_len[j]; i++) begin
        send_sample(SAMPLE_W'(256 + int'(i >= 4) + int'(i >= 504) + int'(i > jump_ticks[j])),
                    CHAN_W'(16'h0300 + j), 16'h0000, i == chan_len[j] - 1);
      end
    end
  endtask

  task automatic test_random_channels();
    int items;
    int chans;
    int phase;
    int pick;
    int len;
    items = 0;
    chans = 0;
    phase = 0;
    while (items < RANDOM_ITEMS || chans < RANDOM_CHANNELS) begin
      if (chans % 8 == 0) begin
        wait_idle();
        if (phase == 0) begin
          write_reg(CFG_RMS_CUT, 24'd0);
          write_reg(CFG_BAD_WORD_LIMIT, 24'd0);
          write_reg(CFG_DUSK_TICK, 24'd0);
          write_reg(CFG_ACTIVITY_LIMIT, 24'd0);
        end else if (phase == 1) begin
          write_reg(CFG_RMS_CUT, 24'd65535);
          write_reg(CFG_BAD_WORD_LIMIT, 24'd4096);
          write_reg(CFG_DUSK_TICK, 24'd4095);
          write_reg(CFG_ACTIVITY_LIMIT, SUM_MAX);
        end else begin
          // stray upper bits must not reach the narrower registers
          write_reg(CFG_RMS_CUT, {8'($urandom), ($urandom_range(0, 3) == 0) ?
                                  16'($urandom) : 16'($urandom_range(0, 3000))});
          write_reg(CFG_BAD_WORD_LIMIT, {11'($urandom), 13'($urandom_range(0, 6))});
          write_reg(CFG_DUSK_TICK, {12'($urandom), ($urandom_range(0, 3) == 0) ?
                                    12'($urandom) : 12'($urandom_range(0, 30))});
          write_reg(CFG_ACTIVITY_LIMIT, ($urandom_range(0, 3) == 0) ?
                                        24'($urandom) : 24'($urandom_range(0, 40000)));
        end
        phase++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) len = $urandom_range(17, 80);
      else len = $urandom_range(1, 16);
      send_channel(len, wave_e'($urandom_range(0, 5)), CHAN_W'($urandom));
      items += len;
      chans++;
    end
  endtask

  always @(posedge clk_i) begin : check_verdict
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict for channel %0d with none expected", out_ch.channel_out);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.channel_out !== want.channel_out) begin
          $error("channel_out: expected %0d, got %0d", want.channel_out, out_ch.channel_out);
          mismatch_count++;
        end
        if (out_ch.is_bad !== want.is_bad) begin
          $error("is_bad: expected %0b, got %0b", want.is_bad, out_ch.is_bad);
          mismatch_count++;
        end
        if (out_ch.rms_flag !== want.rms_flag) begin
          $error("rms_flag: expected %0b, got %0b", want.rms_flag, out_ch.rms_flag);
          mismatch_count++;
        end
        if (out_ch.bad_word_flag !== want.bad_word_flag) begin
          $error("bad_word_flag: expected %0b, got %0b", want.bad_word_flag,
                 out_ch.bad_word_flag);
          mismatch_count++;
        end
        if (out_ch.parity_stuck !== want.parity_stuck) begin
          $error("parity_stuck: expected %0b, got %0b", want.parity_stuck, out_ch.parity_stuck);
          mismatch_count++;
        end
        if (out_ch.activity_flag !== want.activity_flag) begin
          $error("activity_flag: expected %0b, got %0b", want.activity_flag,
                 out_ch.activity_flag);
          mismatch_count++;
        end
      end
    end
  end

  // Verdict side back-pressure: free-flowing, random, and solid stall stretches
  initial begin : verdict_stalls
    int mode;
    int span;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          default: out_ch.ready = 1'b0;
        endcase
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_RMS_CUT;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.channel_id  = '0;
    in_ch.channel_rms = '0;
    in_ch.last_sample = 1'b0;
    flag_cfg = '{rms_cut: RMS_CUT_RST, bad_word_limit: BAD_WORD_LIMIT_RST,
                 dusk_tick: DUSK_TICK_RST, activity_limit: ACTIVITY_LIMIT_RST};
    chan = CHAN_CLEAR;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_cuts();
    test_activity_windows();
    test_random_channels();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/dncf_pkg.sv
hdl/dncf_if.sv
hdl/dncf_cfg_regs.sv
hdl/dncf_accum.sv
hdl/dncf_verdict.sv
hdl/digital_noise_channel_flagger.sv
bench/digital_noise_channel_flagger_test.sv
